// ===== sv/est_pkg.sv =====
// Shared types, constants and helper functions for the Euler transform matrix pipeline.
package est_pkg;

    localparam int CordicSteps = 16;
    localparam int NumStages   = CordicSteps + 7;
    // Payload stage whose scale factors meet the rotation entries.
    localparam int PayScale    = CordicSteps + 4;

    localparam logic signed [20:0] QPi      = 21'sd205887;
    localparam logic signed [20:0] QHalfPi  = 21'sd102944;
    localparam logic signed [20:0] QTwoPi   = 21'sd411775;
    localparam logic signed [35:0] CordicX0 = 36'sd652032874;

    localparam logic signed [23:0] EntryMax = 24'sh7FFFFF;
    localparam logic signed [23:0] EntryMin = -24'sh800000;

    typedef struct packed {
        logic signed [35:0] x;
        logic signed [35:0] y;
        logic signed [20:0] z;
        logic               neg;
    } t_cor;

    typedef struct packed {
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic signed [15:0] scale_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_pay;

    function automatic logic signed [20:0] atan_q16(input logic [3:0] idx);
        logic signed [20:0] v;
        case (idx)
            4'd0:    v = 21'sd51472;
            4'd1:    v = 21'sd30386;
            4'd2:    v = 21'sd16055;
            4'd3:    v = 21'sd8150;
            4'd4:    v = 21'sd4091;
            4'd5:    v = 21'sd2047;
            4'd6:    v = 21'sd1024;
            4'd7:    v = 21'sd512;
            4'd8:    v = 21'sd256;
            4'd9:    v = 21'sd128;
            4'd10:   v = 21'sd64;
            4'd11:   v = 21'sd32;
            4'd12:   v = 21'sd16;
            4'd13:   v = 21'sd8;
            4'd14:   v = 21'sd4;
            default: v = 21'sd2;
        endcase
        return v;
    endfunction

    // Scale a Q4.12 angle to Q.16, wrap it into [-pi, pi], then fold into
    // [-pi/2, pi/2]; a fold flips the sign of the cosine.
    function automatic t_cor angle_prep(input logic signed [15:0] ang);
        logic signed [20:0] a;
        t_cor               c;
        a = {{1{ang[15]}}, ang, 4'b0000};
        if (a > QPi) begin
            a = a - QTwoPi;
        end else if (a < -QPi) begin
            a = a + QTwoPi;
        end
        c.neg = 1'b0;
        if (a > QHalfPi) begin
            a     = QPi - a;
            c.neg = 1'b1;
        end else if (a < -QHalfPi) begin
            a     = -QPi - a;
            c.neg = 1'b1;
        end
        c.x = CordicX0;
        c.y = '0;
        c.z = a;
        return c;
    endfunction

endpackage

// ===== sv/est_cordic_stage.sv =====
// One registered CORDIC rotation step applied to the three angle lanes.
module est_cordic_stage (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [3:0]           i_step,
    input  est_pkg::t_cor [2:0]  i_d,
    output est_pkg::t_cor [2:0]  o_q
);
    import est_pkg::*;

    t_cor [2:0]         n_q;
    t_cor [2:0]         r_q;
    logic signed [20:0] w_atan;

    assign w_atan = atan_q16(i_step);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_q[k].neg = i_d[k].neg;
            if (i_d[k].z >= 0) begin
                n_q[k].x = i_d[k].x - (i_d[k].y >>> i_step);
                n_q[k].y = i_d[k].y + (i_d[k].x >>> i_step);
                n_q[k].z = i_d[k].z - w_atan;
            end else begin
                n_q[k].x = i_d[k].x + (i_d[k].y >>> i_step);
                n_q[k].y = i_d[k].y - (i_d[k].x >>> i_step);
                n_q[k].z = i_d[k].z + w_atan;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ===== sv/euler_scale_transform_matrix.sv =====
// Top level: Y-X-Z Euler scale-rotate-translate matrix pipeline.
//
// Slave channel: one transaction carries angle_x/y/z (Q4.12 radians),
// scale_x/y/z (Q8.8) and pos_x/y/z (Q16.16). Master channel: one transaction
// carries the nine scaled rotation entries m00..m22 (Q8.16, saturated) and
// the translation tx/ty/tz passed through unchanged.
// The pipeline has 23 register stages: one of angle wrap and fold, 16
// CORDIC steps (one per stage, all three angles in parallel), cosine/sine
// rounding, pairwise trig products, triple products, sums, the scale
// multiply, and a round and saturate stage that is the output register.
// Throughput is one transaction per cycle while the receiver does not
// stall the output; every stage holds one item.
// The whole pipeline advances together; when the receiver holds i_m_tready
// low with a result waiting, all stages freeze and o_s_tready drops, so
// nothing is lost or repeated.
// Reset clears all stage valid bits; data registers are not reset.
module euler_scale_transform_matrix (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // angle_x, angle_y, angle_z, scale_x, scale_y, scale_z, pos_x, pos_y, pos_z
    input  logic [191:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22, tx, ty, tz
    output logic [311:0] o_m_tdata
);
    import est_pkg::*;

    logic                 w_en;
    logic [NumStages-1:0] r_v;
    t_pay                 r_pay [0:NumStages-1];
    t_cor [2:0]           w_cor [0:CordicSteps];
    t_cor [2:0]           r_prep;
    t_pay                 w_in_pay;

    assign w_en       = !r_v[NumStages-1] || i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_v[NumStages-1];

    assign w_in_pay.scale_x = i_s_tdata[63:48];
    assign w_in_pay.scale_y = i_s_tdata[79:64];
    assign w_in_pay.scale_z = i_s_tdata[95:80];
    assign w_in_pay.pos_x   = i_s_tdata[127:96];
    assign w_in_pay.pos_y   = i_s_tdata[159:128];
    assign w_in_pay.pos_z   = i_s_tdata[191:160];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NumStages-2:0], i_s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pay[0] <= w_in_pay;
            for (int s = 1; s < NumStages; s++) begin
                r_pay[s] <= r_pay[s-1];
            end
        end
    end

    // Lane 0 is angle_x, lane 1 angle_y, lane 2 angle_z.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prep[0] <= angle_prep(i_s_tdata[15:0]);
            r_prep[1] <= angle_prep(i_s_tdata[31:16]);
            r_prep[2] <= angle_prep(i_s_tdata[47:32]);
        end
    end

    assign w_cor[0] = r_prep;

    for (genvar g = 0; g < CordicSteps; g++) begin : g_cordic
        est_cordic_stage u_stage (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_step (4'(g)),
            .i_d    (w_cor[g]),
            .o_q    (w_cor[g+1])
        );
    end

    // Rounded cosine and sine, Q.15.
    logic signed [17:0] r_c [0:2];
    logic signed [17:0] r_s [0:2];
    logic signed [35:0] w_xr [0:2];
    logic signed [35:0] w_yr [0:2];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_xr[k] = (w_cor[CordicSteps][k].x + 36'sd16384) >>> 15;
            w_yr[k] = (w_cor[CordicSteps][k].y + 36'sd16384) >>> 15;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_c[k] <= w_cor[CordicSteps][k].neg ? -w_xr[k][17:0] : w_xr[k][17:0];
                r_s[k] <= w_yr[k][17:0];
            end
        end
    end

    // Naming follows the usual formula: 1 is y, 2 is x, 3 is z.
    logic signed [17:0] w_c1, w_s1, w_c2, w_s2, w_c3, w_s3;
    assign w_c1 = r_c[1];
    assign w_s1 = r_s[1];
    assign w_c2 = r_c[0];
    assign w_s2 = r_s[0];
    assign w_c3 = r_c[2];
    assign w_s3 = r_s[2];

    // Pairwise products, exact Q.30.
    logic signed [35:0] r_s1s2, r_c1s2, r_c1c3, r_c2s3, r_c3s1, r_c1s3;
    logic signed [35:0] r_c2c3, r_s1s3, r_c2s1, r_c1c2;
    logic signed [17:0] r_p_s3, r_p_c3, r_p_s2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1s2 <= 36'(w_s1) * 36'(w_s2);
            r_c1s2 <= 36'(w_c1) * 36'(w_s2);
            r_c1c3 <= 36'(w_c1) * 36'(w_c3);
            r_c2s3 <= 36'(w_c2) * 36'(w_s3);
            r_c3s1 <= 36'(w_c3) * 36'(w_s1);
            r_c1s3 <= 36'(w_c1) * 36'(w_s3);
            r_c2c3 <= 36'(w_c2) * 36'(w_c3);
            r_s1s3 <= 36'(w_s1) * 36'(w_s3);
            r_c2s1 <= 36'(w_c2) * 36'(w_s1);
            r_c1c2 <= 36'(w_c1) * 36'(w_c2);
            r_p_s3 <= w_s3;
            r_p_c3 <= w_c3;
            r_p_s2 <= w_s2;
        end
    end

    // Triple products, rounded from Q.45 to Q.30.
    logic signed [53:0] w_t [0:3];
    logic signed [39:0] r_t [0:3];
    logic signed [39:0] r_q_c1c3, r_q_c2s3, r_q_c3s1, r_q_c1s3;
    logic signed [39:0] r_q_c2c3, r_q_s1s3, r_q_c2s1, r_q_c1c2, r_q_ns2;

    always_comb begin
        w_t[0] = (54'(r_s1s2) * 54'(r_p_s3) + 54'sd16384) >>> 15;
        w_t[1] = (54'(r_c1s2) * 54'(r_p_s3) + 54'sd16384) >>> 15;
        w_t[2] = (54'(r_s1s2) * 54'(r_p_c3) + 54'sd16384) >>> 15;
        w_t[3] = (54'(r_c1s2) * 54'(r_p_c3) + 54'sd16384) >>> 15;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                r_t[k] <= w_t[k][39:0];
            end
            r_q_c1c3 <= 40'(r_c1c3);
            r_q_c2s3 <= 40'(r_c2s3);
            r_q_c3s1 <= 40'(r_c3s1);
            r_q_c1s3 <= 40'(r_c1s3);
            r_q_c2c3 <= 40'(r_c2c3);
            r_q_s1s3 <= 40'(r_s1s3);
            r_q_c2s1 <= 40'(r_c2s1);
            r_q_c1c2 <= 40'(r_c1c2);
            r_q_ns2  <= -(40'(r_p_s2) <<< 15);
        end
    end

    // Rotation entries, exact sums in Q.30.
    logic signed [39:0] r_rot [0:8];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rot[0] <= r_q_c1c3 + r_t[0];
            r_rot[1] <= r_q_c2s3;
            r_rot[2] <= r_t[1] - r_q_c3s1;
            r_rot[3] <= r_t[2] - r_q_c1s3;
            r_rot[4] <= r_q_c2c3;
            r_rot[5] <= r_t[3] + r_q_s1s3;
            r_rot[6] <= r_q_c2s1;
            r_rot[7] <= r_q_ns2;
            r_rot[8] <= r_q_c1c2;
        end
    end

    // Scale multiply, Q.30 times Q8.8 gives Q.38.
    logic signed [55:0] r_prod [0:8];
    logic signed [15:0] w_scale [0:8];

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            if (k < 3) begin
                w_scale[k] = r_pay[PayScale].scale_x;
            end else if (k < 6) begin
                w_scale[k] = r_pay[PayScale].scale_y;
            end else begin
                w_scale[k] = r_pay[PayScale].scale_z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 9; k++) begin
                r_prod[k] <= 56'(w_scale[k]) * 56'(r_rot[k]);
            end
        end
    end

    // Round to Q.16 and saturate into the output register.
    logic signed [55:0] w_rnd [0:8];
    logic signed [23:0] n_m [0:8];
    logic signed [23:0] r_m [0:8];

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w_rnd[k] = (r_prod[k] + 56'sd2097152) >>> 22;
            if (w_rnd[k] > 56'(EntryMax)) begin
                n_m[k] = EntryMax;
            end else if (w_rnd[k] < 56'(EntryMin)) begin
                n_m[k] = EntryMin;
            end else begin
                n_m[k] = w_rnd[k][23:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 9; k++) begin
                r_m[k] <= n_m[k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            o_m_tdata[k*24 +: 24] = r_m[k];
        end
        o_m_tdata[247:216] = r_pay[NumStages-1].pos_x;
        o_m_tdata[279:248] = r_pay[NumStages-1].pos_y;
        o_m_tdata[311:280] = r_pay[NumStages-1].pos_z;
    end

    a_accept_enters : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_v[0])
        else $error("accepted transaction did not enter the pipeline");

    a_stall_freezes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_v))
        else $error("pipeline valid bits moved during a stall");

    a_hold_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

    a_ready_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[NumStages-1] |-> o_s_tready)
        else $error("input blocked with output stage empty");

endmodule
